/* rtl/qiecf_pkg.sv */
// Shared types, constants and lookup tables for the QIE charge threshold flag block.
package qiecf_pkg;

    localparam int unsigned HitWordWidth   = 14;
    localparam int unsigned CodeWidth      = 8;
    localparam int unsigned MantWidth      = 6;
    localparam int unsigned ChargeWidth    = 19;
    localparam int unsigned EdgeWidth      = 18;
    localparam int unsigned SensWidth      = 14;
    localparam int unsigned OffsetWidth    = 5;
    localparam int unsigned PedestalWidth  = 10;
    localparam int unsigned ThresholdWidth = 12;
    localparam int unsigned AmpWidth       = 17;
    localparam int unsigned QuotWidth      = 13;
    localparam int unsigned CfgIndexWidth  = 2;
    localparam int unsigned CfgDataWidth   = 12;

    // Largest amplitude that any ADC code can produce: floor(343549 / 160).
    localparam int unsigned AmpMax = 2147;

    // Division by 5 after the shift by 5: x * 52429 >> 18 is exact for x below 2^16.
    localparam logic [16:0] RecipFive = 17'd52429;
    localparam int unsigned RecipShift = 18;

    localparam logic [PedestalWidth-1:0]  PedestalReset = 10'd36;
    localparam logic [ThresholdWidth-1:0] HitThrReset   = 12'd10;
    localparam logic [ThresholdWidth-1:0] PileThrReset  = 12'd30;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_PEDESTAL  = 2'd0,
        CFG_HIT_THR   = 2'd1,
        CFG_PILE_THR  = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PedestalWidth-1:0]  pedestal;
        logic [ThresholdWidth-1:0] hit_threshold;
        logic [ThresholdWidth-1:0] pileup_threshold;
    } cfg_regs_t;

    // Control that travels with an item down the pipeline.
    typedef struct packed {
        logic valid;
        logic data_ready;
    } stage_tag_t;

    function automatic logic [MantWidth-1:0] bin_start(input logic [1:0] sub);
        logic [MantWidth-1:0] start;
        unique case (sub)
            2'd0: start = 6'd0;
            2'd1: start = 6'd16;
            2'd2: start = 6'd36;
            2'd3: start = 6'd57;
        endcase
        return start;
    endfunction

    function automatic logic [EdgeWidth-1:0] sub_edge(input logic [3:0] k);
        logic [EdgeWidth-1:0] edge_val;
        unique case (k)
            4'd0:  edge_val = 18'd0;
            4'd1:  edge_val = 18'd34;
            4'd2:  edge_val = 18'd158;
            4'd3:  edge_val = 18'd419;
            4'd4:  edge_val = 18'd517;
            4'd5:  edge_val = 18'd915;
            4'd6:  edge_val = 18'd1910;
            4'd7:  edge_val = 18'd3990;
            4'd8:  edge_val = 18'd4780;
            4'd9:  edge_val = 18'd7960;
            4'd10: edge_val = 18'd15900;
            4'd11: edge_val = 18'd32600;
            4'd12: edge_val = 18'd38900;
            4'd13: edge_val = 18'd64300;
            4'd14: edge_val = 18'd128000;
            4'd15: edge_val = 18'd261000;
        endcase
        return edge_val;
    endfunction

    function automatic logic [SensWidth-1:0] sub_sens(input logic [3:0] k);
        logic [SensWidth-1:0] sens;
        unique case (k)
            4'd0:  sens = 14'd3;
            4'd1:  sens = 14'd6;
            4'd2:  sens = 14'd12;
            4'd3:  sens = 14'd25;
            4'd4:  sens = 14'd25;
            4'd5:  sens = 14'd50;
            4'd6:  sens = 14'd99;
            4'd7:  sens = 14'd198;
            4'd8:  sens = 14'd198;
            4'd9:  sens = 14'd397;
            4'd10: sens = 14'd794;
            4'd11: sens = 14'd1587;
            4'd12: sens = 14'd1587;
            4'd13: sens = 14'd3174;
            4'd14: sens = 14'd6349;
            4'd15: sens = 14'd12700;
        endcase
        return sens;
    endfunction

endpackage

/* rtl/qiecf_cfg.sv */
// Configuration register file: pedestal and the two amplitude thresholds.
module qiecf_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qiecf_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [qiecf_pkg::CfgDataWidth-1:0]  cfg_data,
    output qiecf_pkg::cfg_regs_t                cfg_regs
);

    qiecf_pkg::cfg_regs_t regs_reg;
    qiecf_pkg::cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign cfg_regs  = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            unique case (qiecf_pkg::cfg_index_t'(cfg_index))
                qiecf_pkg::CFG_PEDESTAL:
                    regs_next.pedestal = cfg_data[qiecf_pkg::PedestalWidth-1:0];
                qiecf_pkg::CFG_HIT_THR:
                    regs_next.hit_threshold = cfg_data;
                qiecf_pkg::CFG_PILE_THR:
                    regs_next.pileup_threshold = cfg_data;
                qiecf_pkg::CFG_UNUSED:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pedestal         <= qiecf_pkg::PedestalReset;
            regs_reg.hit_threshold    <= qiecf_pkg::HitThrReset;
            regs_reg.pileup_threshold <= qiecf_pkg::PileThrReset;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

/* rtl/qiecf_charge.sv */
// Linearisation stage: turns the 8-bit ADC code into a charge and registers it.
module qiecf_charge
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  qiecf_pkg::stage_tag_t               tag_in,
    input  logic [qiecf_pkg::CodeWidth-1:0]     code,
    output qiecf_pkg::stage_tag_t               tag_out,
    output logic [qiecf_pkg::ChargeWidth-1:0]   charge
);

    logic [1:0]                          range;
    logic [qiecf_pkg::MantWidth-1:0]     mant;
    logic [1:0]                          sub;
    logic [3:0]                          k;
    logic [qiecf_pkg::SensWidth-1:0]     sens;
    logic [qiecf_pkg::MantWidth-1:0]     offset_full;
    logic [qiecf_pkg::OffsetWidth-1:0]   offset;
    logic [qiecf_pkg::ChargeWidth-1:0]   product;
    logic [qiecf_pkg::ChargeWidth:0]     charge_sum;

    qiecf_pkg::stage_tag_t               tag_reg;
    logic [qiecf_pkg::ChargeWidth-1:0]   charge_reg;
    logic [qiecf_pkg::ChargeWidth-1:0]   charge_next;

    always_comb
    begin
        range = code[qiecf_pkg::CodeWidth-1:qiecf_pkg::MantWidth];
        mant  = code[qiecf_pkg::MantWidth-1:0];
        // A mantissa equal to a bin start still belongs to the lower subrange.
        sub   = 2'((mant > qiecf_pkg::bin_start(2'd1)) ? 1 : 0)
              + 2'((mant > qiecf_pkg::bin_start(2'd2)) ? 1 : 0)
              + 2'((mant > qiecf_pkg::bin_start(2'd3)) ? 1 : 0);
        k     = {range, sub};
        sens  = qiecf_pkg::sub_sens(k);
        offset_full = mant - qiecf_pkg::bin_start(sub);
        offset      = offset_full[qiecf_pkg::OffsetWidth-1:0];
        // The bin offset times the sensitivity needs up to 18 bits.
        product     = qiecf_pkg::ChargeWidth'(offset) * qiecf_pkg::ChargeWidth'(sens);
        charge_sum  = (qiecf_pkg::ChargeWidth+1)'(qiecf_pkg::sub_edge(k))
                    + (qiecf_pkg::ChargeWidth+1)'(product)
                    + (qiecf_pkg::ChargeWidth+1)'(sens >> 1)
                    - (qiecf_pkg::ChargeWidth+1)'(1);
        charge_next = charge_sum[qiecf_pkg::ChargeWidth-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (advance)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            charge_reg <= charge_next;
        end
    end

    assign tag_out = tag_reg;
    assign charge  = charge_reg;

endmodule

/* rtl/qiecf_scale.sv */
// Scaling stage: pedestal subtraction, division by 160, threshold flags, result register.
module qiecf_scale
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  qiecf_pkg::stage_tag_t               tag_in,
    input  logic [qiecf_pkg::ChargeWidth-1:0]   charge,
    input  qiecf_pkg::cfg_regs_t                cfg_regs,
    output logic                                valid_out,
    output logic                                hit_on,
    output logic [qiecf_pkg::AmpWidth-1:0]      amplitude,
    output logic                                pileup
);

    logic [qiecf_pkg::ChargeWidth:0]   diff;
    logic                              above_ped;
    logic [13:0]                       diff_shr;
    logic [30:0]                       prod;
    logic [qiecf_pkg::QuotWidth-1:0]   quot;
    logic                              keep;

    logic                              valid_reg;
    logic                              hit_reg;
    logic                              hit_next;
    logic                              pile_reg;
    logic                              pile_next;
    logic [qiecf_pkg::AmpWidth-1:0]    amp_reg;
    logic [qiecf_pkg::AmpWidth-1:0]    amp_next;

    always_comb
    begin
        diff      = {1'b0, charge} - (qiecf_pkg::ChargeWidth+1)'(cfg_regs.pedestal);
        above_ped = ~diff[qiecf_pkg::ChargeWidth];
        // 160 = 32 * 5: drop five bits, then divide by five via the reciprocal.
        diff_shr  = diff[qiecf_pkg::ChargeWidth-1:5];
        prod      = 31'(diff_shr) * 31'(qiecf_pkg::RecipFive);
        quot      = prod[30:qiecf_pkg::RecipShift];
        keep      = tag_in.data_ready & above_ped;
        amp_next  = keep ? qiecf_pkg::AmpWidth'(quot) : '0;
        hit_next  = keep & (quot >= qiecf_pkg::QuotWidth'(cfg_regs.hit_threshold));
        pile_next = keep & (quot >= qiecf_pkg::QuotWidth'(cfg_regs.pileup_threshold));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg  <= hit_next;
            pile_reg <= pile_next;
            amp_reg  <= amp_next;
        end
    end

    assign valid_out = valid_reg;
    assign hit_on    = hit_reg;
    assign pileup    = pile_reg;
    assign amplitude = amp_reg;

endmodule

/* rtl/qie_adc_charge_threshold_flag.sv */
// Top level of the QIE ADC linearisation and charge threshold flag block.
//
// Usage: each input transaction carries one raw channel word (hit_word) and a
// data_ready bit. Bits 13:6 of the word are the ADC code. The block turns the
// code into a charge, subtracts the pedestal, divides by 160 and compares the
// amplitude with the hit and pileup thresholds. Every input transaction gives
// exactly one output transaction; when data_ready is low all result fields are 0.
//
// The pipeline has three registered stages (input, charge, result), and one item is
// accepted in every cycle for as long as the receiver takes results. The charge
// multiply and the reciprocal multiply each sit in a stage of their own.
//
// When the receiver raises out_stall the result register holds, and the stages
// behind it fill; in_stall rises only once every stage holds an item, so up to
// three items can be in flight while the output waits.
//
// Reset clears every stage's valid bit and loads the register defaults
// (pedestal 36, hit threshold 10, pileup threshold 30). The configuration port
// is always ready; it should be written only while the pipeline is empty.
module qie_adc_charge_threshold_flag
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [qiecf_pkg::HitWordWidth-1:0]    hit_word,
    input  logic                                  data_ready,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  hit_on,
    output logic [qiecf_pkg::AmpWidth-1:0]        amplitude,
    output logic                                  pileup,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qiecf_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [qiecf_pkg::CfgDataWidth-1:0]    cfg_data
);

    qiecf_pkg::cfg_regs_t               cfg_regs;

    // Input register stage.
    qiecf_pkg::stage_tag_t              in_tag_reg;
    qiecf_pkg::stage_tag_t              in_tag_next;
    logic [qiecf_pkg::CodeWidth-1:0]    code_reg;

    qiecf_pkg::stage_tag_t              charge_tag;
    logic [qiecf_pkg::ChargeWidth-1:0]  charge;

    // A stage may load when it is empty or when the stage after it moves on.
    logic out_advance;
    logic charge_advance;
    logic in_advance;

    assign out_advance    = ~out_valid | ~out_stall;
    assign charge_advance = ~charge_tag.valid | out_advance;
    assign in_advance     = ~in_tag_reg.valid | charge_advance;
    assign in_stall       = ~in_advance;

    always_comb
    begin
        in_tag_next.valid      = in_valid;
        in_tag_next.data_ready = data_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tag_reg <= '0;
        end
        else if (in_advance)
        begin
            in_tag_reg <= in_tag_next;
        end
    end

    // The low six bits of the word carry no part of the ADC code.
    always_ff @(posedge clk)
    begin
        if (in_advance)
        begin
            code_reg <= hit_word[qiecf_pkg::HitWordWidth-1:qiecf_pkg::MantWidth];
        end
    end

    qiecf_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_regs  (cfg_regs)
    );

    qiecf_charge u_charge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (charge_advance),
        .tag_in  (in_tag_reg),
        .code    (code_reg),
        .tag_out (charge_tag),
        .charge  (charge)
    );

    qiecf_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (out_advance),
        .tag_in    (charge_tag),
        .charge    (charge),
        .cfg_regs  (cfg_regs),
        .valid_out (out_valid),
        .hit_on    (hit_on),
        .amplitude (amplitude),
        .pileup    (pileup)
    );

    // Input back-pressure only when every stage is occupied and the output is held.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_tag_reg.valid && charge_tag.valid && out_valid && out_stall))
        else $error("input stalled while a pipeline stage was free");

    // No ADC code yields an amplitude above the largest possible quotient.
    a_amplitude_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (amplitude <= qiecf_pkg::AmpWidth'(qiecf_pkg::AmpMax)))
        else $error("amplitude beyond the range of the linearised charge");

    // A result can only appear if the charge stage held an item the cycle before.
    a_result_from_charge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(charge_tag.valid))
        else $error("result appeared without an item in the charge stage");

    // A charge-stage item can only appear from an occupied input register.
    a_charge_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(charge_tag.valid) |-> $past(in_tag_reg.valid))
        else $error("charge stage loaded without an item in the input register");

endmodule

/* tb/qie_flag_checker.sv */
// Checker that predicts and compares the results of the QIE charge threshold flag block.
`timescale 1ns / 100ps

module qie_flag_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [qiecf_pkg::HitWordWidth-1:0]   hit_word,
    input  logic                                 data_ready,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 hit_on,
    input  logic [qiecf_pkg::AmpWidth-1:0]       amplitude,
    input  logic                                 pileup,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [qiecf_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [qiecf_pkg::CfgDataWidth-1:0]   cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   results_checked
);

    typedef struct packed {
        logic                           hit;
        logic [qiecf_pkg::AmpWidth-1:0] amp;
        logic                           pile;
    } flag_result_t;

    localparam int unsigned AmpDivisor = 160;
    localparam int unsigned BinFirst [4] = '{0, 16, 36, 57};
    localparam int unsigned ChargeBase [16] = '{
        0, 34, 158, 419, 517, 915, 1910, 3990,
        4780, 7960, 15900, 32600, 38900, 64300, 128000, 261000
    };
    localparam int unsigned LsbWeight [16] = '{
        3, 6, 12, 25, 25, 50, 99, 198,
        198, 397, 794, 1587, 1587, 3174, 6349, 12700
    };

    flag_result_t                          expected_flags [$];
    logic [qiecf_pkg::PedestalWidth-1:0]   ped_q;
    logic [qiecf_pkg::ThresholdWidth-1:0]  hit_thr_q;
    logic [qiecf_pkg::ThresholdWidth-1:0]  pile_thr_q;
    int                                    fails = 0;
    int                                    checked = 0;

    assign fail_count      = fails;
    assign results_checked = checked;

    // Linearises the ADC code, removes the pedestal, scales to amplitude and sets the flags.
    function automatic flag_result_t linearise_and_flag(
        input logic [qiecf_pkg::HitWordWidth-1:0]   word,
        input logic                                 ready,
        input logic [qiecf_pkg::PedestalWidth-1:0]  ped,
        input logic [qiecf_pkg::ThresholdWidth-1:0] hit_thr,
        input logic [qiecf_pkg::ThresholdWidth-1:0] pile_thr
    );
        flag_result_t res;
        int unsigned  mant;
        int unsigned  sub;
        int unsigned  k;
        int unsigned  charge;
        int unsigned  quot;
        res = '0;
        if (ready)
        begin
            mant = word[11:6];
            sub  = 0;
            if (mant > BinFirst[1]) sub++;
            if (mant > BinFirst[2]) sub++;
            if (mant > BinFirst[3]) sub++;
            k      = 4 * word[13:12] + sub;
            charge = ChargeBase[k] + (mant - BinFirst[sub]) * LsbWeight[k]
                   + LsbWeight[k] / 2 - 1;
            // Below the pedestal nothing is flagged, even with a zero threshold.
            if (charge >= ped)
            begin
                quot     = (charge - ped) / AmpDivisor;
                res.amp  = quot[qiecf_pkg::AmpWidth-1:0];
                res.hit  = (quot >= hit_thr);
                res.pile = (quot >= pile_thr);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        fails++;
        $display("[%0t] %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        flag_result_t want;
        if (!rst_n)
        begin
            ped_q      <= qiecf_pkg::PedestalReset;
            hit_thr_q  <= qiecf_pkg::HitThrReset;
            pile_thr_q <= qiecf_pkg::PileThrReset;
            expected_flags.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_flags.push_back(linearise_and_flag(hit_word, data_ready,
                                                            ped_q, hit_thr_q, pile_thr_q));
            if (out_valid && !out_stall)
            begin
                if (expected_flags.size() == 0)
                    report_mismatch($sformatf("unexpected result, amplitude %0d", amplitude));
                else
                begin
                    want = expected_flags.pop_front();
                    if (hit_on !== want.hit)
                        report_mismatch($sformatf("result %0d hit_on: got %0b, expected %0b",
                                                  checked, hit_on, want.hit));
                    if (amplitude !== want.amp)
                        report_mismatch($sformatf("result %0d amplitude: got %0d, expected %0d",
                                                  checked, amplitude, want.amp));
                    if (pileup !== want.pile)
                        report_mismatch($sformatf("result %0d pileup: got %0b, expected %0b",
                                                  checked, pileup, want.pile));
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qiecf_pkg::CFG_PEDESTAL:
                        ped_q <= cfg_data[qiecf_pkg::PedestalWidth-1:0];
                    qiecf_pkg::CFG_HIT_THR:
                        hit_thr_q <= cfg_data;
                    qiecf_pkg::CFG_PILE_THR:
                        pile_thr_q <= cfg_data;
                    default: ;
                endcase
            end
        end
        pending = expected_flags.size();
    end

endmodule

/* tb/tb_qie_adc_charge_threshold_flag.sv */
// Testbench top: stimulus, handshake idling and verdict for the QIE charge threshold flag block.
`timescale 1ns / 100ps

module tb_qie_adc_charge_threshold_flag;

    // Cycles without any accepted transaction before the run is declared hung.
    localparam int QuietLimit = 2000;
    // Cycles allowed after the last expected result before a register write or the verdict.
    localparam int SettleCycles = 6;
    localparam int RandomPhases = 6;
    localparam int ItemsPerPhase = 100;
    // Mantissas on either side of each subrange boundary, plus both ends.
    localparam logic [qiecf_pkg::MantWidth-1:0] BoundaryMant [8] =
        '{6'd0, 6'd16, 6'd17, 6'd36, 6'd37, 6'd57, 6'd58, 6'd63};

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic [qiecf_pkg::HitWordWidth-1:0]   hit_word;
    logic                                 data_ready;
    logic                                 out_valid;
    logic                                 out_stall;
    logic                                 hit_on;
    logic [qiecf_pkg::AmpWidth-1:0]       amplitude;
    logic                                 pileup;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [qiecf_pkg::CfgIndexWidth-1:0]  cfg_index;
    logic [qiecf_pkg::CfgDataWidth-1:0]   cfg_data;

    int  check_failures;
    int  in_flight;
    int  results_seen;
    int  items_sent = 0;
    int  reg_writes = 0;
    int  settings_used = 1;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    // Cleared for the final phase so that the block also runs at full rate.
    bit  idle_on = 1'b1;

    qie_adc_charge_threshold_flag u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hit_word   (hit_word),
        .data_ready (data_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit_on     (hit_on),
        .amplitude  (amplitude),
        .pileup     (pileup),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // The checker sees exactly what the block sees and keeps its own copy of the registers.
    qie_flag_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .hit_word        (hit_word),
        .data_ready      (data_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit_on          (hit_on),
        .amplitude       (amplitude),
        .pileup          (pileup),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (check_failures),
        .pending         (in_flight),
        .results_checked (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiver stalls in random bursts, decided at each falling edge so that the stall
    // is steady by the time the block samples it.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(1, 19) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: any accepted transaction on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("Watchdog expired after %0d idle cycles with %0d results outstanding",
                     QuietLimit, in_flight);
            $display("qie_adc_charge_threshold_flag test failed");
            $finish;
        end
    end

    // Builds a raw word from a range and mantissa; the six low bits are ignored by the block,
    // so they are filled with noise.
    function automatic logic [qiecf_pkg::HitWordWidth-1:0] adc_word(
        input logic [1:0]                    rng,
        input logic [qiecf_pkg::MantWidth-1:0] mant);
        logic [5:0] noise;
        noise = 6'($urandom);
        return {rng, mant, noise};
    endfunction

    // The sender holds the transaction until it is taken, and then sometimes leaves a gap.
    // Valid stays high between back-to-back transactions, so it is never dropped and raised
    // within the same time step.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic push_item(input logic [qiecf_pkg::HitWordWidth-1:0] word, input logic ready);
        @(negedge clk);
        in_valid   <= 1'b1;
        hit_word   <= word;
        data_ready <= ready;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (idle_on && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 19));
    endtask

    // Holds the sender off until every expected result has come back, then lets the pipeline
    // settle. This is the only safe point for register writes.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (in_flight != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // The configuration port is always ready, but the handshake is still honoured.
    task automatic write_reg(input qiecf_pkg::cfg_index_t idx,
                             input logic [qiecf_pkg::CfgDataWidth-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [qiecf_pkg::CfgDataWidth-1:0] ped,
                                  input logic [qiecf_pkg::CfgDataWidth-1:0] hit_thr,
                                  input logic [qiecf_pkg::CfgDataWidth-1:0] pile_thr);
        drain_pipeline();
        write_reg(qiecf_pkg::CFG_PEDESTAL, ped);
        write_reg(qiecf_pkg::CFG_HIT_THR, hit_thr);
        write_reg(qiecf_pkg::CFG_PILE_THR, pile_thr);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Pedestal data is twelve bits wide on the port, so the upper two bits are exercised too.
    function automatic logic [qiecf_pkg::CfgDataWidth-1:0] pick_pedestal();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return qiecf_pkg::CfgDataWidth'($urandom);
        endcase
    endfunction

    // Amplitudes never exceed a little over two thousand, so most thresholds land below that
    // and the flags change state often.
    function automatic logic [qiecf_pkg::CfgDataWidth-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return qiecf_pkg::CfgDataWidth'($urandom);
            3:       return qiecf_pkg::CfgDataWidth'($urandom_range(0, 30));
            default: return qiecf_pkg::CfgDataWidth'($urandom_range(0, 2200));
        endcase
    endfunction

    // Random traffic: mostly valid samples, a share placed on the subrange boundaries, and a
    // share of samples that are not ready.
    task automatic push_random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            push_item(qiecf_pkg::HitWordWidth'($urandom), 1'b0);
        else if (roll < 35)
            push_item(adc_word(2'($urandom), BoundaryMant[$urandom_range(0, 7)]), 1'b1);
        else
            push_item(qiecf_pkg::HitWordWidth'($urandom), 1'b1);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        hit_word   = '0;
        data_ready = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = qiecf_pkg::CFG_PEDESTAL;
        cfg_data   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: a zero charge sits below the pedestal, the largest code gives the
        // largest charge, a sample that is not ready gives all zeros, and each subrange
        // boundary is tried on both sides, where a mantissa equal to a bin start still
        // belongs to the lower subrange.
        push_item('0, 1'b1);
        push_item('1, 1'b0);
        push_item('1, 1'b1);
        push_item(adc_word(2'd0, 6'd16), 1'b1);
        push_item(adc_word(2'd0, 6'd17), 1'b1);
        push_item(adc_word(2'd1, 6'd36), 1'b1);
        push_item(adc_word(2'd1, 6'd37), 1'b1);
        push_item(adc_word(2'd2, 6'd57), 1'b1);
        push_item(adc_word(2'd2, 6'd58), 1'b1);
        push_item(adc_word(2'd3, 6'd63), 1'b1);
        push_item(adc_word(2'd3, 6'd0), 1'b1);
        push_item('0, 1'b0);

        // A write to the spare index must leave every register as it was.
        drain_pipeline();
        write_reg(qiecf_pkg::CFG_UNUSED, '1);
        @(negedge clk);
        cfg_valid <= 1'b0;

        // Everything at zero: even a zero amplitude meets a zero threshold.
        apply_settings('0, '0, '0);
        push_item('0, 1'b1);
        push_item(adc_word(2'd1, 6'd0), 1'b1);
        push_item('1, 1'b1);

        // Largest pedestal with a zero hit threshold: a charge below the pedestal still
        // raises no flag, and the top threshold is never reached.
        apply_settings('1, '0, '1);
        push_item('0, 1'b1);
        push_item('1, 1'b1);

        // Thresholds at and just above an amplitude of three.
        apply_settings('0, 12'd3, 12'd4);
        push_item(adc_word(2'd1, 6'd0), 1'b1);
        push_item(adc_word(2'd1, 6'd0), 1'b0);

        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            if (phase == RandomPhases - 1)
                idle_on = 1'b0;
            apply_settings(pick_pedestal(), pick_threshold(), pick_threshold());
            for (int i = 0; i < ItemsPerPhase; i++)
            begin
                // Once mid-phase, let the whole pipeline empty before carrying on.
                if (phase == 1 && i == ItemsPerPhase / 2)
                    drain_pipeline();
                push_random_item();
            end
        end

        drain_pipeline();
        $display("Sent %0d samples and checked %0d results under %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("(%0d register writes, including the spare index and both extremes)",
                 reg_writes);
        if (check_failures == 0)
            $display("qie_adc_charge_threshold_flag test passed");
        else
            $display("qie_adc_charge_threshold_flag test failed");
        $finish;
    end

endmodule
